// ===== hdl/segtree_pkg.sv =====
// Package for the segment tree range sum block: field widths, function codes
// and the controller state type. No dependencies.
package segtree_pkg;

    localparam int IDX_W  = 10;
    localparam int DATA_W = 64;

    typedef enum logic {
        FUNC_SET   = 1'b0,
        FUNC_QUERY = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SET_LEAF,
        S_SET_UP,
        S_Q_WALK,
        S_Q_DRAIN,
        S_OUT
    } t_state;

endpackage

// ===== hdl/segtree_mem.sv =====
// Node store of the segment tree: one write port, two read ports with
// registered read data. Depends on nothing.
module segtree_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = 64
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re_a,
    input  logic [AW-1:0] i_raddr_a,
    output logic [DW-1:0] o_rdata_a,
    input  logic          i_re_b,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_b
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata_a;
    logic [DW-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re_a) begin
            r_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== hdl/segment_tree_range_sum.sv =====
// Top level of the segment tree range sum block: controller, walk datapath
// and accumulator. Depends on segtree_pkg and segtree_mem.
//
// Usage. An item is taken on a rising edge with start high and busy low.
// i_func selects a set (store i_value at position i_index_a) or a query
// (sum of positions i_index_a..i_index_b, both included, wrapping mod 2^64).
// A set gives no result; a set beyond the last position is dropped.
// A query gives one result: o_valid is high for exactly one cycle with the
// sum on o_range_sum. The receiver cannot stall, so take it then.
// Empty or out-of-range queries return zero; a right bound past the end
// is clamped to the last position.
// Sequence. A set of leaf node k (k = LEAVES + position) keeps busy high
// while it writes the leaf and then each ancestor up to the root: one node
// write per tree level, with each sibling read registered from the node
// store ahead of the write that uses it. A query walks the two bounds up
// the tree, one level per cycle using both read ports, then passes through
// S_Q_DRAIN while the add pipeline drains; o_valid is raised in S_OUT.
// Reset. After reset the node store clears all 2*LEAVES nodes, one node
// per cycle, with busy held high throughout.
module segment_tree_range_sum #(
    parameter int LEAVES = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_func,
    input  logic [segtree_pkg::IDX_W-1:0]    i_index_a,
    input  logic [segtree_pkg::IDX_W-1:0]    i_index_b,
    input  logic signed [segtree_pkg::DATA_W-1:0] i_value,
    output logic                             o_valid,
    output logic signed [segtree_pkg::DATA_W-1:0] o_range_sum
);

    localparam int DW    = segtree_pkg::DATA_W;
    localparam int DEPTH = 2 * LEAVES;
    // node address width, and width of the half-open walk bounds
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);
    // working width for comparing raw indexes against LEAVES
    localparam int EW    = ((NW > segtree_pkg::IDX_W) ? NW : segtree_pkg::IDX_W) + 1;
    localparam logic [EW-1:0] LEAVES_E  = EW'(LEAVES);
    localparam logic [AW-1:0] LAST_NODE = AW'(DEPTH - 1);
    localparam logic [AW-1:0] ROOT_NODE = AW'(1);

    segtree_pkg::t_state r_state, n_state;

    logic [NW-1:0] r_lo, n_lo;
    logic [NW-1:0] r_hi, n_hi;
    logic [AW-1:0] r_node, n_node;
    logic [DW-1:0] r_cur, n_cur;
    logic [AW-1:0] r_clr, n_clr;
    logic          r_fa, n_fa;
    logic          r_fb, n_fb;
    logic [DW-1:0] r_pair;
    logic [DW-1:0] r_acc, n_acc;

    // node store ports
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic          mem_re_a;
    logic [AW-1:0] mem_raddr_a;
    logic [DW-1:0] mem_rdata_a;
    logic          mem_re_b;
    logic [AW-1:0] mem_raddr_b;
    logic [DW-1:0] mem_rdata_b;

    // decode of an incoming item
    logic [EW-1:0] idx_a_e;
    logic [EW-1:0] idx_b_e;
    logic [EW-1:0] idx_b_cl;
    logic          q_empty;
    logic          set_oor;
    logic [NW-1:0] lo_init;
    logic [NW-1:0] hi_init;
    logic [AW-1:0] leaf_addr;
    logic [EW-1:0] leaf_e;
    logic [EW-1:0] lo_e;
    logic [EW-1:0] hi_e;

    logic [NW-1:0] hi_m1;
    logic [DW-1:0] up_sum;
    logic          accept;

    assign accept = start && !busy;

    always_comb begin
        idx_a_e  = EW'(i_index_a);
        idx_b_e  = EW'(i_index_b);
        idx_b_cl = (idx_b_e >= LEAVES_E) ? (LEAVES_E - EW'(1)) : idx_b_e;
        q_empty  = (idx_a_e > idx_b_e) || (idx_a_e >= LEAVES_E);
        set_oor  = (idx_a_e >= LEAVES_E);
        leaf_e   = idx_a_e + LEAVES_E;
        lo_e     = leaf_e;
        hi_e     = idx_b_cl + LEAVES_E + EW'(1);
        // an empty range walks nothing: both bounds at zero
        lo_init  = q_empty ? '0 : lo_e[NW-1:0];
        hi_init  = q_empty ? '0 : hi_e[NW-1:0];
        leaf_addr = leaf_e[AW-1:0];
    end

    assign hi_m1  = r_hi - NW'(1);
    // the parent takes the carried child value plus the sibling just read
    assign up_sum = r_cur + mem_rdata_a;

    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_node      = r_node;
        n_cur       = r_cur;
        n_clr       = r_clr;
        n_fa        = 1'b0;
        n_fb        = 1'b0;
        n_acc       = r_acc + r_pair;
        mem_we      = 1'b0;
        mem_waddr   = r_node;
        mem_wdata   = r_cur;
        mem_re_a    = 1'b0;
        mem_raddr_a = r_node ^ AW'(1);
        mem_re_b    = 1'b0;
        mem_raddr_b = hi_m1[AW-1:0];

        unique case (r_state)
            segtree_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + AW'(1);
                if (r_clr == LAST_NODE) begin
                    n_state = segtree_pkg::S_IDLE;
                end
            end
            segtree_pkg::S_IDLE: begin
                if (start) begin
                    if (i_func == segtree_pkg::FUNC_QUERY) begin
                        n_lo    = lo_init;
                        n_hi    = hi_init;
                        n_acc   = '0;
                        n_state = segtree_pkg::S_Q_WALK;
                    end else if (!set_oor) begin
                        n_node  = leaf_addr;
                        n_cur   = i_value;
                        n_state = segtree_pkg::S_SET_LEAF;
                    end
                end
            end
            segtree_pkg::S_SET_LEAF: begin
                // write the leaf, fetch its sibling
                mem_we   = 1'b1;
                mem_re_a = 1'b1;
                n_node   = r_node >> 1;
                n_state  = segtree_pkg::S_SET_UP;
            end
            segtree_pkg::S_SET_UP: begin
                mem_we    = 1'b1;
                mem_wdata = up_sum;
                n_cur     = up_sum;
                if (r_node != ROOT_NODE) begin
                    mem_re_a = 1'b1;
                    n_node   = r_node >> 1;
                end else begin
                    n_state = segtree_pkg::S_IDLE;
                end
            end
            segtree_pkg::S_Q_WALK: begin
                if (r_lo < r_hi) begin
                    // odd left bound and odd right bound each pull one node
                    mem_re_a    = r_lo[0];
                    mem_raddr_a = r_lo[AW-1:0];
                    mem_re_b    = r_hi[0];
                    n_fa        = r_lo[0];
                    n_fb        = r_hi[0];
                    n_lo        = (r_lo + NW'(r_lo[0])) >> 1;
                    n_hi        = r_hi >> 1;
                end else begin
                    n_state = segtree_pkg::S_Q_DRAIN;
                end
            end
            segtree_pkg::S_Q_DRAIN: begin
                n_state = segtree_pkg::S_OUT;
            end
            segtree_pkg::S_OUT: begin
                n_state = segtree_pkg::S_IDLE;
            end
            default: begin
                n_state = segtree_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= segtree_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_fa   <= 1'b0;
            r_fb   <= 1'b0;
            r_pair <= '0;
            r_acc  <= '0;
        end else begin
            r_clr  <= n_clr;
            r_fa   <= n_fa;
            r_fb   <= n_fb;
            // mask nodes that were not fetched, then fold into the sum
            r_pair <= (r_fa ? mem_rdata_a : '0) + (r_fb ? mem_rdata_b : '0);
            r_acc  <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_node <= n_node;
        r_cur  <= n_cur;
    end

    segtree_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_re_a    (mem_re_a),
        .i_raddr_a (mem_raddr_a),
        .o_rdata_a (mem_rdata_a),
        .i_re_b    (mem_re_b),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_b (mem_rdata_b)
    );

    assign busy        = (r_state != segtree_pkg::S_IDLE);
    assign o_valid     = (r_state == segtree_pkg::S_OUT);
    assign o_range_sum = r_acc;

    // result strobe lasts exactly one cycle
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    // an accepted query always occupies the block
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_func == segtree_pkg::FUNC_QUERY)) |=> busy)
        else $error("query transfer did not start a walk");

    // the sibling fetch never targets the node written in the same cycle
    a_set_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == segtree_pkg::S_SET_UP) && mem_re_a) |-> (mem_raddr_a != mem_waddr))
        else $error("set walk read and write hit the same node");

    // pipeline is drained while the result is shown
    a_out_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!r_fa && !r_fb && (r_pair == '0)))
        else $error("partial sums still in flight at result");

endmodule

// ===== tb/sv/tb_segment_tree_range_sum.sv =====
// Self-checking testbench for segment_tree_range_sum: point writes and range-sum queries
// against a leaf-array shadow of the tree, with random start gaps. Depends on segtree_pkg and segment_tree_range_sum.
module tb_segment_tree_range_sum;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W  = segtree_pkg::IDX_W;
    localparam int DATA_W = segtree_pkg::DATA_W;

    localparam int LEAVES = 1024;
    localparam int SETTLE_CYCLES = 40;     // longest walk is well under this
    localparam logic signed [DATA_W-1:0] MAX_S = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] MIN_S = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct {
        segtree_pkg::t_func       func;
        logic [IDX_W-1:0]         idx_a;
        logic [IDX_W-1:0]         idx_b;
        logic signed [DATA_W-1:0] value;
    } t_seg_cmd;

    typedef struct {
        logic [IDX_W-1:0]  lo;
        logic [IDX_W-1:0]  hi;
        logic [DATA_W-1:0] sum;
    } t_sum_due;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     start       = 1'b0;
    logic                     i_func      = 1'b0;
    logic [IDX_W-1:0]         i_index_a   = '0;
    logic [IDX_W-1:0]         i_index_b   = '0;
    logic signed [DATA_W-1:0] i_value     = '0;
    logic                     busy;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_range_sum;

    // Shadow of the leaf level; every inner node is just a sum of these.
    logic [DATA_W-1:0] shadow_leaf [LEAVES];
    t_seg_cmd          cmd_backlog [$];
    t_sum_due          sums_due [$];
    int                error_count    = 0;
    int                transfers_done = 0;
    int                gap_left       = 0;

    segment_tree_range_sum #(
        .LEAVES(LEAVES)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_func      (i_func),
        .i_index_a   (i_index_a),
        .i_index_b   (i_index_b),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_range_sum (o_range_sum)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // One line per mismatch; the count decides the final verdict.
    task automatic flag_error(input string what);
        error_count++;
        $display("ERROR @%0t: %s", $time, what);
    endtask

    // Wrapped sum over an inclusive range, with the block's clamping rules.
    function automatic logic [DATA_W-1:0] range_total(int unsigned lo, int unsigned hi);
        logic [DATA_W-1:0] acc;
        acc = '0;
        if (lo > hi || lo >= LEAVES) return '0;
        if (hi >= LEAVES) hi = LEAVES - 1;
        for (int unsigned p = lo; p <= hi; p++) acc += shadow_leaf[p];
        return acc;
    endfunction

    // Apply an accepted transfer to the shadow, queueing the sum a query owes.
    task automatic track_transfer(input t_seg_cmd cmd);
        t_sum_due due;
        if (cmd.func == segtree_pkg::FUNC_SET) begin
            if (cmd.idx_a < LEAVES) shadow_leaf[cmd.idx_a] = cmd.value;
        end else begin
            due.lo  = cmd.idx_a;
            due.hi  = cmd.idx_b;
            due.sum = range_total(cmd.idx_a, cmd.idx_b);
            sums_due.push_back(due);
        end
    endtask

    function automatic void queue_cmd(segtree_pkg::t_func f, int unsigned a, int unsigned b,
                                      logic signed [DATA_W-1:0] v);
        t_seg_cmd cmd;
        cmd.func  = f;
        cmd.idx_a = a[IDX_W-1:0];
        cmd.idx_b = b[IDX_W-1:0];
        cmd.value = v;
        cmd_backlog.push_back(cmd);
    endfunction

    // Values lean towards the extremes so that partial sums wrap often.
    function automatic logic signed [DATA_W-1:0] pick_value();
        int unsigned              pick;
        logic signed [DATA_W-1:0] v;
        pick = $urandom_range(99);
        if (pick < 40) begin
            v = {$urandom, $urandom};
        end else if (pick < 60) begin
            v = DATA_W'(int'($urandom_range(2000)) - 1000);
        end else if (pick < 75) begin
            case ($urandom_range(3))
                0: v = MAX_S;
                1: v = MIN_S;
                2: v = '1;
                default: v = '0;
            endcase
        end else if (pick < 88) begin
            v = MAX_S - DATA_W'($urandom_range(1000));
        end else begin
            v = MIN_S + DATA_W'($urandom_range(1000));
        end
        return v;
    endfunction

    // Half the positions fall in a narrow window so that queries see recent writes.
    function automatic int unsigned pick_pos(int unsigned hot_base);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 50) return hot_base + $urandom_range(31);
        if (pick < 55) return ($urandom_range(1) != 0) ? LEAVES - 1 : 0;
        return $urandom_range(LEAVES - 1);
    endfunction

    // Idle freely, except in a quiet stretch mid-run and over the tail.
    function automatic bit idling_allowed();
        if (cmd_backlog.size() <= 60) return 1'b0;
        if (transfers_done >= 150 && transfers_done < 230) return 1'b0;
        return 1'b1;
    endfunction

    // Driver: a transfer happens on an edge with start high and busy low.
    // Payload follows the head of the backlog, so it holds steady until taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                track_transfer(cmd_backlog.pop_front());
                transfers_done++;
            end
            // A gap may open at any cycle, even while an item waits on busy,
            // so that start rises at every point of the block's walk.
            if (gap_left == 0 && idling_allowed() && $urandom_range(99) < 15)
                gap_left = $urandom_range(6, 1);
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
                start     <= 1'b1;
                i_func    <= cmd_backlog[0].func;
                i_index_a <= cmd_backlog[0].idx_a;
                i_index_b <= cmd_backlog[0].idx_b;
                i_value   <= cmd_backlog[0].value;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: a result lives for one cycle only; take it on the edge ending it.
    always @(posedge i_clk) begin : result_check
        t_sum_due due;
        if (i_rst_n && o_valid === 1'b1) begin
            if (sums_due.size() == 0) begin
                flag_error($sformatf("result %h with no query outstanding", o_range_sum));
            end else begin
                due = sums_due.pop_front();
                if (o_range_sum !== due.sum)
                    flag_error($sformatf("sum [%0d..%0d]: got %h, want %h",
                                         due.lo, due.hi, o_range_sum, due.sum));
            end
        end
    end

    initial begin : stimulus
        int unsigned hot_base;
        int unsigned a;
        int unsigned b;
        int unsigned shape;

        foreach (shadow_leaf[p]) shadow_leaf[p] = '0;

        // Directed part: freshly cleared tree, both ends of every field, empty and
        // single-element ranges, and wrap-around in both directions. With ten-bit
        // indices and 1024 leaves no set or query bound can fall past the end.
        queue_cmd(segtree_pkg::FUNC_QUERY, 0, LEAVES - 1, '0);
        queue_cmd(segtree_pkg::FUNC_SET, 0, LEAVES - 1, MAX_S);
        queue_cmd(segtree_pkg::FUNC_SET, 1, 0, DATA_W'(1));
        queue_cmd(segtree_pkg::FUNC_QUERY, 0, 1, '0);
        queue_cmd(segtree_pkg::FUNC_SET, LEAVES - 1, 0, MIN_S);
        queue_cmd(segtree_pkg::FUNC_QUERY, 0, LEAVES - 1, '1);
        queue_cmd(segtree_pkg::FUNC_QUERY, LEAVES - 1, LEAVES - 1, '0);
        queue_cmd(segtree_pkg::FUNC_QUERY, LEAVES - 1, 0, '0);
        queue_cmd(segtree_pkg::FUNC_QUERY, 5, 4, '0);
        queue_cmd(segtree_pkg::FUNC_QUERY, 0, 0, '0);
        queue_cmd(segtree_pkg::FUNC_SET, 512, 511, '1);
        queue_cmd(segtree_pkg::FUNC_QUERY, 511, 513, '0);
        queue_cmd(segtree_pkg::FUNC_SET, LEAVES - 2, LEAVES - 1, '0);
        queue_cmd(segtree_pkg::FUNC_SET, 2, 0, MAX_S);
        queue_cmd(segtree_pkg::FUNC_QUERY, 0, 2, '0);
        queue_cmd(segtree_pkg::FUNC_SET, 3, 0, {(DATA_W/2){2'b01}});
        queue_cmd(segtree_pkg::FUNC_SET, 4, 0, {(DATA_W/2){2'b10}});
        queue_cmd(segtree_pkg::FUNC_QUERY, 3, 4, '0);
        queue_cmd(segtree_pkg::FUNC_SET, 0, 0, '0);
        queue_cmd(segtree_pkg::FUNC_QUERY, 1, LEAVES - 2, '0);
        queue_cmd(segtree_pkg::FUNC_SET, 1, 0, MIN_S);
        queue_cmd(segtree_pkg::FUNC_QUERY, 0, LEAVES - 1, '0);
        queue_cmd(segtree_pkg::FUNC_QUERY, 1, 1, '0);

        // Random part: writes and queries mixed, range shapes weighted towards
        // short spans near recent writes, with some empty and full-width ranges.
        hot_base = $urandom_range(LEAVES - 32);
        for (int n = 0; n < 450; n++) begin
            if (n % 64 == 63) hot_base = $urandom_range(LEAVES - 32);
            a = pick_pos(hot_base);
            if ($urandom_range(99) < 45) begin
                queue_cmd(segtree_pkg::FUNC_SET, a, $urandom_range(LEAVES - 1),
                          pick_value());
            end else begin
                shape = $urandom_range(99);
                if (shape < 40) begin
                    b = a + $urandom_range(40);
                    if (b > LEAVES - 1) b = LEAVES - 1;
                end else if (shape < 70) begin
                    b = $urandom_range(LEAVES - 1);
                end else if (shape < 80) begin
                    b = a;
                end else if (shape < 90) begin
                    a = ($urandom_range(1) != 0) ? 0 : a;
                    b = ($urandom_range(1) != 0) ? LEAVES - 1 : a;
                end else begin
                    if (a == 0) a = 1;
                    b = $urandom_range(a - 1);
                end
                queue_cmd(segtree_pkg::FUNC_QUERY, a, b, {$urandom, $urandom});
            end
        end

        // Hold reset, then release it; the block then clears its node store
        // with busy high, which the driver simply waits out.
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0) @(posedge i_clk);
        while (sums_due.size() != 0) @(posedge i_clk);
        // Let a trailing write finish and catch any stray result.
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0 && sums_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Guard against a hang: the clearing pass plus about 480 transfers stays far below this.
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
